>>> hw/rtl/rhc_pkg.sv
// Shared types and constants of the RGB to HSL color classifier.
// Field widths, register indexes, class codes and hue band bounds.
// No dependencies; every other file of the block imports this package.
package rhc_pkg;

    localparam int PIX_W      = 8;
    localparam int HUE_W      = 9;
    localparam int FRAC_W     = 17;
    localparam int CLASS_W    = 4;
    localparam int DARK_W     = 9;
    localparam int GRAY_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Division pipeline shape: 16 fraction bits, two quotient bits per stage.
    localparam int FRAC_BITS       = 16;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = FRAC_BITS / STEPS_PER_STAGE;
    localparam int LQ_W            = FRAC_BITS + 2;
    localparam int HUE_Q_BITS      = 6;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_SAT_LIMIT = 2'd2;

    localparam logic [DARK_W-1:0] DARK_LIMIT_RESET     = 9'd102;
    localparam logic [DARK_W-1:0] LIGHT_LIMIT_RESET    = 9'd408;
    localparam logic [GRAY_W-1:0] GRAY_SAT_LIMIT_RESET = 17'd16384;

    localparam logic [CLASS_W-1:0] CLS_BLACK   = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_WHITE   = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_GRAY    = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_RED     = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_YELLOW  = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_GREEN   = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_CYAN    = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_BLUE    = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_MAGENTA = 4'd8;

    localparam logic [HUE_W-1:0] HUE_RED_END     = 9'd30;
    localparam logic [HUE_W-1:0] HUE_YELLOW_END  = 9'd90;
    localparam logic [HUE_W-1:0] HUE_GREEN_END   = 9'd150;
    localparam logic [HUE_W-1:0] HUE_CYAN_END    = 9'd210;
    localparam logic [HUE_W-1:0] HUE_BLUE_END    = 9'd270;
    localparam logic [HUE_W-1:0] HUE_MAGENTA_END = 9'd330;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE  = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE   = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN   = 9'd360;

    // Which channel holds the maximum.
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0] sector;
        logic       neg;
        logic       gray;
    } rhc_hue_ctl_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue_degrees;
        logic [FRAC_W-1:0]  saturation;
        logic [FRAC_W-1:0]  lightness;
        logic [CLASS_W-1:0] color_class;
    } rhc_result_t;

endpackage

>>> hw/rtl/rhc_if.sv
// Channel interfaces of the RGB to HSL color classifier: pixel input,
// result output and configuration write channel.
// Depends on rhc_pkg for the field widths.
interface rhc_pixel_if import rhc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsl_if import rhc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue_degrees;
    logic [FRAC_W-1:0]  saturation;
    logic [FRAC_W-1:0]  lightness;
    logic [CLASS_W-1:0] color_class;

    modport source (output valid, output hue_degrees, output saturation,
                    output lightness, output color_class, input ready);
    modport sink (input valid, input hue_degrees, input saturation,
                  input lightness, input color_class, output ready);
endinterface

interface rhc_cfg_if import rhc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rgb_to_hsl_color_classifier_unit.sv
// Top level of the RGB to HSL color classifier.
// Depends on rhc_pkg, the channel interfaces in rhc_if and rhc_div_pipe.
//
// Usage:
// The pixel channel takes one word of red, green and blue; the low CHANNEL_BITS
// bits of each are used. The result channel gives one word per pixel with hue in
// whole degrees, saturation and lightness with 16 fraction bits, and the color
// class. The cfg channel writes the dark, light and gray saturation limits by
// index; it is always ready and should be used only while no pixel is in flight.
// A pixel accepted on the pixel channel passes the stage 1, 2 and 3 registers,
// the eight division stages, the final register and the output register before
// its result is valid. Throughput is one pixel per clock while the receiver does
// not stall; the divider retires two quotient bits per stage over eight stages.
// Reset empties the pipeline and loads the limits with 102, 408 and 16384.
// When the receiver stalls, the result word holds and one more word goes to a
// skid register; then pixel ready drops and the whole pipeline freezes, with no
// word lost or repeated. Ready comes straight from a register.
module rgb_to_hsl_color_classifier_unit import rhc_pkg::*; #(
    parameter int CHANNEL_BITS = 8
) (
    input logic       clk,
    input logic       rst_n,
    rhc_cfg_if.sink   cfg,
    rhc_pixel_if.sink pixel,
    rhc_hsl_if.source result
);

    localparam int CB   = CHANNEL_BITS;
    localparam int HW   = CB + HUE_Q_BITS;
    localparam int CMPW = (CB + 1 > DARK_W) ? CB + 1 : DARK_W;
    localparam logic [CB-1:0] FULL    = {CB{1'b1}};
    localparam logic [CB:0]   FULL_X2 = {FULL, 1'b0};

    logic [DARK_W-1:0] dark_limit_reg;
    logic [DARK_W-1:0] light_limit_reg;
    logic [GRAY_W-1:0] gray_limit_reg;

    logic en;

    logic          s1_valid_reg;
    logic [CB-1:0] s1_hi_reg, s1_lo_reg, s1_x_reg;
    logic [1:0]    s1_sector_reg;
    logic          s1_neg_reg;
    logic [CB-1:0] s1_hi_next, s1_lo_next, s1_x_next;
    logic [1:0]    s1_sector_next;
    logic          s1_neg_next;

    logic          s2_valid_reg;
    logic [CB-1:0] s2_delta_reg;
    logic [CB:0]   s2_sum_reg;
    logic [HW-1:0] s2_hr_reg;
    logic          s2_lo_zero_reg, s2_hi_full_reg;
    logic [1:0]    s2_sector_reg;
    logic          s2_neg_reg;

    logic              s3_valid_reg;
    logic [CB-1:0]     s3_den_reg, s3_delta_reg, s3_sr_reg, s3_lr_reg;
    logic [FRAC_W-1:0] s3_sq_reg;
    logic [LQ_W-1:0]   s3_lq_reg;
    logic [HW-1:0]     s3_hr_reg;
    logic [CB:0]       s3_sum_reg;
    rhc_hue_ctl_t      s3_ctl_reg;
    logic [CB-1:0]     s3_den_next, s3_sr_next, s3_lr_next;
    logic [FRAC_W-1:0] s3_sq_next;
    logic [LQ_W-1:0]   s3_lq_next;

    logic                  d_valid;
    logic [FRAC_W-1:0]     d_sq;
    logic [LQ_W-1:0]       d_lq;
    logic [HUE_Q_BITS-1:0] d_hq;
    logic                  d_hr_nz;
    logic [CB:0]           d_sum;
    rhc_hue_ctl_t          d_ctl;

    logic              fin_valid_reg;
    logic [HUE_W-1:0]  fin_hue_reg;
    logic [FRAC_W-1:0] fin_sat_reg;
    logic [FRAC_W-1:0] fin_light_reg;
    logic [CB:0]       fin_sum_reg;
    logic [HUE_W-1:0]  fin_hue_next;

    rhc_result_t fin_word;
    rhc_result_t out_word_reg, out_word_next;
    rhc_result_t skid_word_reg, skid_word_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_limit_reg  <= DARK_LIMIT_RESET;
            light_limit_reg <= LIGHT_LIMIT_RESET;
            gray_limit_reg  <= GRAY_SAT_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DARK_LIMIT:     dark_limit_reg  <= cfg.data[DARK_W-1:0];
                CFG_LIGHT_LIMIT:    light_limit_reg <= cfg.data[DARK_W-1:0];
                CFG_GRAY_SAT_LIMIT: gray_limit_reg  <= cfg.data[GRAY_W-1:0];
                default:            ;
            endcase
        end
    end

    // The pipeline moves as a whole while the skid register is empty.
    assign en          = !skid_valid_reg;
    assign pixel.ready = en;

    // ---------------- stage 1: maximum, minimum and hue difference ----------------
    always_comb
    begin
        logic [CB-1:0] r, g, b;
        logic          red_max, green_max;
        r         = CB'(pixel.red);
        g         = CB'(pixel.green);
        b         = CB'(pixel.blue);
        red_max   = (r >= g) && (r >= b);
        green_max = !red_max && (g >= b);
        s1_lo_next = ((r <= g) && (r <= b)) ? r : ((g <= b) ? g : b);
        if (red_max)
        begin
            s1_hi_next     = r;
            s1_sector_next = SEC_RED;
            s1_neg_next    = (g < b);
            s1_x_next      = (g >= b) ? g - b : b - g;
        end
        else if (green_max)
        begin
            s1_hi_next     = g;
            s1_sector_next = SEC_GREEN;
            s1_neg_next    = (b < r);
            s1_x_next      = (b >= r) ? b - r : r - b;
        end
        else
        begin
            s1_hi_next     = b;
            s1_sector_next = SEC_BLUE;
            s1_neg_next    = (r < g);
            s1_x_next      = (r >= g) ? r - g : g - r;
        end
    end

    // ---------------- stage 3: divider set-up ----------------
    always_comb
    begin
        logic       low_half;
        logic       sat_full;
        logic [1:0] lint;
        low_half = (s2_sum_reg <= {1'b0, FULL});
        s3_den_next = low_half ? s2_sum_reg[CB-1:0] : CB'(FULL_X2 - s2_sum_reg);
        // Saturation is exactly one when the minimum is zero on the dark half,
        // or the maximum is full scale on the bright half.
        sat_full   = low_half ? s2_lo_zero_reg : s2_hi_full_reg;
        s3_sr_next = sat_full ? '0 : s2_delta_reg;
        s3_sq_next = FRAC_W'(sat_full);
        if (s2_sum_reg == FULL_X2)
        begin
            lint       = 2'd2;
            s3_lr_next = '0;
        end
        else if (s2_sum_reg >= {1'b0, FULL})
        begin
            lint       = 2'd1;
            s3_lr_next = CB'(s2_sum_reg - {1'b0, FULL});
        end
        else
        begin
            lint       = 2'd0;
            s3_lr_next = s2_sum_reg[CB-1:0];
        end
        s3_lq_next = LQ_W'(lint);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= pixel.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fin_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_hi_reg     <= s1_hi_next;
            s1_lo_reg     <= s1_lo_next;
            s1_x_reg      <= s1_x_next;
            s1_sector_reg <= s1_sector_next;
            s1_neg_reg    <= s1_neg_next;

            s2_delta_reg   <= s1_hi_reg - s1_lo_reg;
            s2_sum_reg     <= {1'b0, s1_hi_reg} + {1'b0, s1_lo_reg};
            s2_hr_reg      <= (HW'(s1_x_reg) << 6) - (HW'(s1_x_reg) << 2);
            s2_lo_zero_reg <= (s1_lo_reg == '0);
            s2_hi_full_reg <= (s1_hi_reg == FULL);
            s2_sector_reg  <= s1_sector_reg;
            s2_neg_reg     <= s1_neg_reg;

            s3_den_reg        <= s3_den_next;
            s3_delta_reg      <= s2_delta_reg;
            s3_sr_reg         <= s3_sr_next;
            s3_sq_reg         <= s3_sq_next;
            s3_lr_reg         <= s3_lr_next;
            s3_lq_reg         <= s3_lq_next;
            s3_hr_reg         <= s2_hr_reg;
            s3_sum_reg        <= s2_sum_reg;
            s3_ctl_reg.sector <= s2_sector_reg;
            s3_ctl_reg.neg    <= s2_neg_reg;
            s3_ctl_reg.gray   <= (s2_delta_reg == '0);

            fin_hue_reg   <= fin_hue_next;
            fin_sat_reg   <= d_ctl.gray ? '0 : d_sq;
            fin_light_reg <= d_lq[LQ_W-1:1];
            fin_sum_reg   <= d_sum;
        end
    end

    rhc_div_pipe #(
        .CB (CB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_den    (s3_den_reg),
        .in_delta  (s3_delta_reg),
        .in_sr     (s3_sr_reg),
        .in_sq     (s3_sq_reg),
        .in_lr     (s3_lr_reg),
        .in_lq     (s3_lq_reg),
        .in_hr     (s3_hr_reg),
        .in_sum    (s3_sum_reg),
        .in_ctl    (s3_ctl_reg),
        .out_valid (d_valid),
        .out_sq    (d_sq),
        .out_lq    (d_lq),
        .out_hq    (d_hq),
        .out_hr_nz (d_hr_nz),
        .out_sum   (d_sum),
        .out_ctl   (d_ctl)
    );

    // ---------------- hue assembly ----------------
    // A negative difference subtracts the rounded-up quotient from the sector base.
    always_comb
    begin
        logic [HUE_W-1:0] q, ceil_q;
        q      = HUE_W'(d_hq);
        ceil_q = q + HUE_W'(d_hr_nz);
        case (d_ctl.sector)
            SEC_RED:   fin_hue_next = d_ctl.neg ? HUE_FULL_TURN - ceil_q : q;
            SEC_GREEN: fin_hue_next = d_ctl.neg ? HUE_GREEN_BASE - ceil_q : HUE_GREEN_BASE + q;
            SEC_BLUE:  fin_hue_next = d_ctl.neg ? HUE_BLUE_BASE - ceil_q : HUE_BLUE_BASE + q;
            default:   fin_hue_next = '0;
        endcase
        if (d_ctl.gray)
        begin
            fin_hue_next = '0;
        end
    end

    // ---------------- classification ----------------
    always_comb
    begin
        fin_word.hue_degrees = fin_hue_reg;
        fin_word.saturation  = fin_sat_reg;
        fin_word.lightness   = fin_light_reg;
        if (CMPW'(fin_sum_reg) < CMPW'(dark_limit_reg))
            fin_word.color_class = CLS_BLACK;
        else if (CMPW'(fin_sum_reg) > CMPW'(light_limit_reg))
            fin_word.color_class = CLS_WHITE;
        else if (fin_sat_reg < gray_limit_reg)
            fin_word.color_class = CLS_GRAY;
        else if (fin_hue_reg < HUE_RED_END)
            fin_word.color_class = CLS_RED;
        else if (fin_hue_reg < HUE_YELLOW_END)
            fin_word.color_class = CLS_YELLOW;
        else if (fin_hue_reg < HUE_GREEN_END)
            fin_word.color_class = CLS_GREEN;
        else if (fin_hue_reg < HUE_CYAN_END)
            fin_word.color_class = CLS_CYAN;
        else if (fin_hue_reg < HUE_BLUE_END)
            fin_word.color_class = CLS_BLUE;
        else if (fin_hue_reg < HUE_MAGENTA_END)
            fin_word.color_class = CLS_MAGENTA;
        else
            fin_word.color_class = CLS_RED;
    end

    // ---------------- output register and skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (result.ready)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_next = fin_valid_reg;
            out_word_next  = fin_word;
        end
        else if (fin_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = fin_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.hue_degrees = out_word_reg.hue_degrees;
    assign result.saturation  = out_word_reg.saturation;
    assign result.lightness   = out_word_reg.lightness;
    assign result.color_class = out_word_reg.color_class;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word present without an output word");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result.valid && !result.ready))
        else $error("skid register filled without a stalled output");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.hue_degrees < HUE_FULL_TURN))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.saturation <= FRAC_ONE))
        else $error("saturation above one");

    a_hue_class_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.color_class >= CLS_RED))
            |-> (result.saturation >= gray_limit_reg))
        else $error("hue class given to a pixel below the gray saturation limit");

endmodule

>>> hw/rtl/rhc_div_pipe.sv
// Pipelined restoring dividers of the color classifier: saturation and
// lightness fractions and the hue quotient, two quotient bits per stage.
// Depends on rhc_pkg.
module rhc_div_pipe import rhc_pkg::*; #(
    parameter int CB = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [CB-1:0]              in_den,
    input  logic [CB-1:0]              in_delta,
    input  logic [CB-1:0]              in_sr,
    input  logic [FRAC_W-1:0]          in_sq,
    input  logic [CB-1:0]              in_lr,
    input  logic [LQ_W-1:0]            in_lq,
    input  logic [CB+HUE_Q_BITS-1:0]   in_hr,
    input  logic [CB:0]                in_sum,
    input  rhc_hue_ctl_t               in_ctl,
    output logic                       out_valid,
    output logic [FRAC_W-1:0]          out_sq,
    output logic [LQ_W-1:0]            out_lq,
    output logic [HUE_Q_BITS-1:0]      out_hq,
    output logic                       out_hr_nz,
    output logic [CB:0]                out_sum,
    output rhc_hue_ctl_t               out_ctl
);

    localparam int HW = CB + HUE_Q_BITS;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    logic                  v_reg     [DIV_STAGES];
    logic [CB-1:0]         den_reg   [DIV_STAGES];
    logic [CB-1:0]         delta_reg [DIV_STAGES];
    logic [CB-1:0]         sr_reg    [DIV_STAGES];
    logic [FRAC_W-1:0]     sq_reg    [DIV_STAGES];
    logic [CB-1:0]         lr_reg    [DIV_STAGES];
    logic [LQ_W-1:0]       lq_reg    [DIV_STAGES];
    logic [HW-1:0]         hr_reg    [DIV_STAGES];
    logic [HUE_Q_BITS-1:0] hq_reg    [DIV_STAGES];
    logic [CB:0]           sum_reg   [DIV_STAGES];
    rhc_hue_ctl_t          ctl_reg   [DIV_STAGES];

    logic                  v_next     [DIV_STAGES];
    logic [CB-1:0]         den_next   [DIV_STAGES];
    logic [CB-1:0]         delta_next [DIV_STAGES];
    logic [CB-1:0]         sr_next    [DIV_STAGES];
    logic [FRAC_W-1:0]     sq_next    [DIV_STAGES];
    logic [CB-1:0]         lr_next    [DIV_STAGES];
    logic [LQ_W-1:0]       lq_next    [DIV_STAGES];
    logic [HW-1:0]         hr_next    [DIV_STAGES];
    logic [HUE_Q_BITS-1:0] hq_next    [DIV_STAGES];
    logic [CB:0]           sum_next   [DIV_STAGES];
    rhc_hue_ctl_t          ctl_next   [DIV_STAGES];

    always_comb
    begin
        logic [CB-1:0]         den;
        logic [CB-1:0]         dl;
        logic [CB-1:0]         sr;
        logic [FRAC_W-1:0]     sq;
        logic [CB-1:0]         lr;
        logic [LQ_W-1:0]       lq;
        logic [HW-1:0]         hr;
        logic [HUE_Q_BITS-1:0] hq;
        logic [CB:0]           r2;
        logic [HW-1:0]         hd;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                v_next[s]   = in_valid;
                den         = in_den;
                dl          = in_delta;
                sr          = in_sr;
                sq          = in_sq;
                lr          = in_lr;
                lq          = in_lq;
                hr          = in_hr;
                hq          = '0;
                sum_next[s] = in_sum;
                ctl_next[s] = in_ctl;
            end
            else
            begin
                v_next[s]   = v_reg[s-1];
                den         = den_reg[s-1];
                dl          = delta_reg[s-1];
                sr          = sr_reg[s-1];
                sq          = sq_reg[s-1];
                lr          = lr_reg[s-1];
                lq          = lq_reg[s-1];
                hr          = hr_reg[s-1];
                hq          = hq_reg[s-1];
                sum_next[s] = sum_reg[s-1];
                ctl_next[s] = ctl_reg[s-1];
            end
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                // Fraction long division: the remainder stays below the divisor.
                r2 = {sr, 1'b0};
                if (r2 >= {1'b0, den})
                begin
                    sr = CB'(r2 - {1'b0, den});
                    sq = {sq[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    sr = CB'(r2);
                    sq = {sq[FRAC_W-2:0], 1'b0};
                end
                r2 = {lr, 1'b0};
                if (r2 >= {1'b0, FULL})
                begin
                    lr = CB'(r2 - {1'b0, FULL});
                    lq = {lq[LQ_W-2:0], 1'b1};
                end
                else
                begin
                    lr = CB'(r2);
                    lq = {lq[LQ_W-2:0], 1'b0};
                end
                // The hue quotient is at most 60, so six shifted-divisor steps suffice.
                hd = '0;
                if (s * STEPS_PER_STAGE + j < HUE_Q_BITS)
                begin
                    hd = HW'(dl) << (HUE_Q_BITS - 1 - (s * STEPS_PER_STAGE + j));
                    if (hr >= hd)
                    begin
                        hr = hr - hd;
                        hq = {hq[HUE_Q_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        hq = {hq[HUE_Q_BITS-2:0], 1'b0};
                    end
                end
            end
            den_next[s]   = den;
            delta_next[s] = dl;
            sr_next[s]    = sr;
            sq_next[s]    = sq;
            lr_next[s]    = lr;
            lq_next[s]    = lq;
            hr_next[s]    = hr;
            hq_next[s]    = hq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                v_reg[s] <= v_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                den_reg[s]   <= den_next[s];
                delta_reg[s] <= delta_next[s];
                sr_reg[s]    <= sr_next[s];
                sq_reg[s]    <= sq_next[s];
                lr_reg[s]    <= lr_next[s];
                lq_reg[s]    <= lq_next[s];
                hr_reg[s]    <= hr_next[s];
                hq_reg[s]    <= hq_next[s];
                sum_reg[s]   <= sum_next[s];
                ctl_reg[s]   <= ctl_next[s];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_sq    = sq_reg[DIV_STAGES-1];
    assign out_lq    = lq_reg[DIV_STAGES-1];
    assign out_hq    = hq_reg[DIV_STAGES-1];
    assign out_hr_nz = (hr_reg[DIV_STAGES-1] != '0);
    assign out_sum   = sum_reg[DIV_STAGES-1];
    assign out_ctl   = ctl_reg[DIV_STAGES-1];

endmodule
